// ===== design/otrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otrb_pkg
// Shared types and constants for the overwriting trace ring buffer.
// ----------------------------------------------------------------------------
package otrb_pkg;

    // Default ring depth in events
    localparam int DEPTH_DEFAULT = 128;

    // Field widths
    localparam int TYPE_W = 8;
    localparam int PID_W  = 31;
    localparam int ARG_W  = 32;
    localparam int TS_W   = 32;
    localparam int SEQ_W  = 32;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 168;

    // Command codes carried on the input tuser
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        ST_RECORDED = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_READ     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // One stored event, as held in a ring slot
    typedef struct packed {
        logic [TS_W-1:0]   time_stamp;
        logic [TYPE_W-1:0] kind;
        logic [PID_W-1:0]  pid;
        logic [ARG_W-1:0]  arg_a;
        logic [ARG_W-1:0]  arg_b;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage : otrb_pkg
`default_nettype wire

// ===== design/overwriting_trace_ring_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer
// Event trace ring that keeps the most recent DEPTH events and overwrites
// the oldest when full. Record commands store an event; read commands return
// the oldest unread event with its sequence number, or report empty.
// ----------------------------------------------------------------------------
// Channel   | Dir | Handshake              | Payload
// s_axis    | in  | i_s_axis_tvalid/tready | tuser: cmd; tdata: event fields
// m_axis    | out | o_m_axis_tvalid/tready | tuser: status; tdata: read event
// cfg       | in  | i_cfg_wr_en            | i_cfg_wr_data: record_enable
//
// One transaction per cycle is accepted while input tready is high; each gives
// one result, registered in the slot RAM read stage, then the output register.
// Reset clears counters, occupancy and valid flags; no memory clear pass,
// and recording is enabled after reset.
// A stalled output holds the pipeline; input tready drops only when both the
// RAM stage and the output register are full.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_buffer
    import otrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input stream
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // [7:0] event_type, [38:8] process_id, [70:39] first_arg,
    // [102:71] second_arg, [134:103] timestamp, [135] zero
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    // [0] cmd
    input  wire logic                i_s_axis_tuser,
    // output stream
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // [31:0] out_sequence, [63:32] out_timestamp, [71:64] out_type,
    // [102:72] out_process_id, [134:103] out_first_arg,
    // [166:135] out_second_arg, [167] zero
    output logic      [M_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic      [1:0]          o_m_axis_tuser,
    // configuration
    input  wire logic                i_cfg_wr_en,
    input  wire logic                i_cfg_wr_data
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic              r_rec_en;
    logic [AW-1:0]     r_wr_slot, n_wr_slot;
    logic [AW-1:0]     r_rd_slot, n_rd_slot;
    logic [SEQ_W-1:0]  r_rd_count, n_rd_count;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic              r_s1_valid;
    t_status           r_s1_status;
    logic [SEQ_W-1:0]  r_s1_seq;

    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    t_status             r_m_status;

    t_slot             wr_slot_data;
    t_slot             rd_slot_data;
    logic [SLOT_W-1:0] rd_raw;

    logic    out_adv;
    logic    acc;
    logic    is_rd;
    logic    rec_do;
    logic    rd_do;
    logic    full;
    logic    empty;
    t_status s0_status;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_adv         = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || out_adv;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign is_rd           = (i_s_axis_tuser == CMD_READ);
    assign full            = (r_fill == FILL_W'(DEPTH));
    assign empty           = (r_fill == '0);
    assign rec_do          = acc && !is_rd && r_rec_en;
    assign rd_do           = acc && is_rd && !empty;

    // status of the accepted transaction
    always_comb begin
        if (is_rd) begin
            s0_status = empty ? ST_EMPTY : ST_READ;
        end else begin
            s0_status = r_rec_en ? ST_RECORDED : ST_IGNORED;
        end
    end

    // ------------------------------------------------------------------
    // Slot RAM
    // ------------------------------------------------------------------
    assign wr_slot_data.kind       = i_s_axis_tdata[7:0];
    assign wr_slot_data.pid        = i_s_axis_tdata[38:8];
    assign wr_slot_data.arg_a      = i_s_axis_tdata[70:39];
    assign wr_slot_data.arg_b      = i_s_axis_tdata[102:71];
    assign wr_slot_data.time_stamp = i_s_axis_tdata[134:103];

    otrb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rec_do),
        .i_wr_addr (r_wr_slot),
        .i_wr_data (wr_slot_data),
        .i_rd_en   (rd_do),
        .i_rd_addr (r_rd_slot),
        .o_rd_data (rd_raw)
    );

    assign rd_slot_data = t_slot'(rd_raw);

    // ------------------------------------------------------------------
    // Counter and pointer updates
    // ------------------------------------------------------------------
    always_comb begin
        n_wr_slot  = r_wr_slot;
        n_rd_slot  = r_rd_slot;
        n_rd_count = r_rd_count;
        n_fill     = r_fill;
        if (rec_do) begin
            n_wr_slot = (r_wr_slot == AW'(DEPTH - 1)) ? '0 : r_wr_slot + 1'b1;
            if (full) begin
                // oldest event is lost: reader is pulled forward by one
                n_rd_slot  = n_wr_slot;
                n_rd_count = r_rd_count + 1'b1;
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end else if (rd_do) begin
            n_rd_slot  = (r_rd_slot == AW'(DEPTH - 1)) ? '0 : r_rd_slot + 1'b1;
            n_rd_count = r_rd_count + 1'b1;
            n_fill     = r_fill - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_en   <= 1'b1;
            r_wr_slot  <= '0;
            r_rd_slot  <= '0;
            r_rd_count <= '0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rec_en <= i_cfg_wr_data;
            end
            r_wr_slot  <= n_wr_slot;
            r_rd_slot  <= n_rd_slot;
            r_rd_count <= n_rd_count;
            r_fill     <= n_fill;
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (out_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_adv) begin
                r_m_valid <= r_s1_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: RAM stage and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_status <= s0_status;
            r_s1_seq    <= r_rd_count;
        end
        if (out_adv && r_s1_valid) begin
            r_m_status <= r_s1_status;
            if (r_s1_status == ST_READ) begin
                r_m_data <= {1'b0,
                             rd_slot_data.arg_b,
                             rd_slot_data.arg_a,
                             rd_slot_data.pid,
                             rd_slot_data.kind,
                             rd_slot_data.time_stamp,
                             r_s1_seq};
            end else begin
                r_m_data <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_status;

`ifndef SYNTHESIS
    // occupancy never exceeds the ring depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("ring occupancy above depth");

    // a read of an empty ring reports empty
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && is_rd && empty |=> r_s1_valid && r_s1_status == ST_EMPTY)
        else $error("empty read not reported");

    // a record into a full ring advances the reader and keeps occupancy
    a_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_do && full |=> r_fill == $past(r_fill) &&
                           r_rd_count == $past(r_rd_count) + 1'b1)
        else $error("overwrite did not pull reader forward");

    // RAM stage holds while the output is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_adv |=> r_s1_valid && $stable(r_s1_seq) &&
                                   $stable(r_s1_status))
        else $error("RAM stage lost a transaction under stall");

    // non-read results carry zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_status != ST_READ |-> r_m_data == '0)
        else $error("non-read result with payload");
`endif

endmodule : overwriting_trace_ring_buffer
`default_nettype wire

// ===== design/otrb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otrb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Read data holds when not enabled.
// ----------------------------------------------------------------------------
module otrb_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : otrb_ram
`default_nettype wire
